// ===== hdl/rsmt_pkg.sv =====
// Shared types, codes and defaults for the record set merge table.
package rsmt_pkg;

    localparam int DEF_TABLE_DEPTH  = 32;
    localparam int DEF_RECORD_BYTES = 8;

    localparam int MODE_W      = 3;
    localparam int RECORD_W    = 64;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_CNT_W = 6;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;
    localparam int POLICY_W    = 2;

    localparam logic [MODE_W-1:0] MODE_BEGIN  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SKIPPED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP_REJ  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN  = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNIQUE_POLICY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SORTED_MODE   = 1'b1;

    localparam logic [POLICY_W-1:0] POLICY_SKIP   = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_REJECT = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [RECORD_W-1:0] record;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [RECORD_W-1:0]    out_record;
        logic                   out_valid;
        logic                   last;
        logic [ENTRY_CNT_W-1:0] entry_count;
        logic                   merge_failed;
    } out_word_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } push_req_t;

endpackage

// ===== hdl/record_set_merge_table.sv =====
// Top level of the record set merge table: sequencer, record memory and configuration.
//
//   port group   dir   handshake            payload
//   s_*          in    s_valid / s_ready    in_word_t  {mode, record}
//   m_*          out   m_valid / m_ready    out_word_t {status, out_record, out_valid,
//                                                       last, entry_count, merge_failed}
//   cfg_*        in    cfg_we               cfg_index, cfg_wdata
//
// One item at a time through a record memory with one write port and one registered read port.
// Begin, clear, load, unknown mode and ignored items go from dispatch straight to the result word.
// Add and remove scan the held records, then shift records up or down where needed;
// a sorted insert that lands inside the table shifts records up before writing the new one.
// Read out: one result word per cycle while m_ready stays high; an empty table gives a single word.
// Reset clears count, failure flag and configuration; memory contents need no clearing.
// A stalled result channel holds the sequencer; the queue absorbs two words.
module record_set_merge_table
    import rsmt_pkg::*;
#(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int RECORD_BYTES = DEF_RECORD_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_data
);

    localparam int REC_W = 8 * RECORD_BYTES;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT_UP,
        ST_INSERT,
        ST_SHIFT_DN,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [MODE_W-1:0]    mode_reg;
    logic [MODE_W-1:0]    mode_next;
    logic [REC_W-1:0]     rec_reg;
    logic [REC_W-1:0]     rec_next;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic                 failed_reg;
    logic                 failed_next;
    logic [POLICY_W-1:0]  policy_reg;
    logic [POLICY_W-1:0]  policy_next;
    logic                 sorted_reg;
    logic                 sorted_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [CNT_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     pos_next;
    logic                 found_reg;
    logic                 found_next;
    logic                 dup_reg;
    logic                 dup_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;

    logic [REC_W-1:0]     mem [TABLE_DEPTH];
    logic [REC_W-1:0]     rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    logic [REC_W-1:0]     mem_wd;

    push_req_t            push;
    logic                 push_ready;

    logic [CNT_W-1:0]     fill_last;
    logic                 is_full;
    logic                 rec_eq;
    logic                 rec_ge;
    logic                 read_last;

    assign s_ready   = (state_reg == ST_IDLE);
    assign fill_last = fill_reg - CNT_W'(1);
    assign is_full   = (fill_reg >= CNT_W'(TABLE_DEPTH));
    assign rec_eq    = (rd_data_reg == rec_reg);
    assign rec_ge    = (rd_data_reg >= rec_reg);
    assign read_last = (cnt_reg == fill_last);

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        rec_next    = rec_reg;
        fill_next   = fill_reg;
        failed_next = failed_reg;
        policy_next = policy_reg;
        sorted_next = sorted_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        dup_next    = dup_reg;
        status_next = status_reg;

        rd_addr = cnt_reg[IDX_W-1:0];
        mem_we  = 1'b0;
        mem_wa  = fill_reg[IDX_W-1:0];
        mem_wd  = rec_reg;

        push.valid             = 1'b0;
        push.word.status       = status_reg;
        push.word.out_record   = '0;
        push.word.out_valid    = 1'b0;
        push.word.last         = 1'b1;
        push.word.entry_count  = ENTRY_CNT_W'(fill_reg);
        push.word.merge_failed = failed_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_UNIQUE_POLICY: policy_next = cfg_wdata[POLICY_W-1:0];
                CFG_SORTED_MODE:   sorted_next = cfg_wdata[0];
                default:           policy_next = policy_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_data.mode;
                    rec_next   = s_data.record[REC_W-1:0];
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                dup_next    = 1'b0;
                found_next  = 1'b0;
                pos_next    = fill_reg;
                cnt_next    = '0;
                rd_addr     = '0;
                status_next = STAT_DONE;
                state_next  = ST_EMIT;
                if (mode_reg == MODE_BEGIN) begin
                    fill_next   = '0;
                    failed_next = 1'b0;
                end else if (failed_reg) begin
                    status_next = STAT_IGNORED;
                end else begin
                    case (mode_reg)
                        MODE_LOAD: begin
                            if (is_full) begin
                                failed_next = 1'b1;
                                status_next = STAT_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        MODE_CLEAR: begin
                            fill_next = '0;
                        end
                        MODE_ADD, MODE_REMOVE: begin
                            state_next = (fill_reg == '0) ? ST_DECIDE : ST_SCAN;
                        end
                        MODE_READ: begin
                            if (fill_reg != '0) begin
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            failed_next = 1'b1;
                            status_next = STAT_UNKNOWN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (rec_eq) begin
                    dup_next = 1'b1;
                end
                if (!found_reg && (((mode_reg == MODE_REMOVE) && rec_eq) ||
                                   ((mode_reg == MODE_ADD) && sorted_reg && rec_ge))) begin
                    found_next = 1'b1;
                    pos_next   = cnt_reg;
                end
                if (read_last) begin
                    state_next = ST_DECIDE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    rd_addr  = IDX_W'(cnt_reg + CNT_W'(1));
                end
            end
            ST_DECIDE: begin
                status_next = STAT_DONE;
                state_next  = ST_EMIT;
                if (mode_reg == MODE_ADD) begin
                    if (dup_reg && (policy_reg == POLICY_SKIP)) begin
                        status_next = STAT_SKIPPED;
                    end else if (dup_reg && (policy_reg == POLICY_REJECT)) begin
                        failed_next = 1'b1;
                        status_next = STAT_DUP_REJ;
                    end else if (is_full) begin
                        failed_next = 1'b1;
                        status_next = STAT_FULL;
                    end else if (pos_reg == fill_reg) begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end else begin
                        rd_addr    = fill_last[IDX_W-1:0];
                        cnt_next   = fill_last;
                        state_next = ST_SHIFT_UP;
                    end
                end else begin
                    if (!found_reg) begin
                        status_next = STAT_SKIPPED;
                    end else if (pos_reg == fill_last) begin
                        fill_next = fill_last;
                    end else begin
                        rd_addr    = IDX_W'(pos_reg + CNT_W'(1));
                        cnt_next   = pos_reg + CNT_W'(1);
                        state_next = ST_SHIFT_DN;
                    end
                end
            end
            ST_SHIFT_UP: begin
                mem_we = 1'b1;
                mem_wa = IDX_W'(cnt_reg + CNT_W'(1));
                mem_wd = rd_data_reg;
                if (cnt_reg == pos_reg) begin
                    state_next = ST_INSERT;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    rd_addr  = IDX_W'(cnt_reg - CNT_W'(1));
                end
            end
            ST_INSERT: begin
                mem_we     = 1'b1;
                mem_wa     = pos_reg[IDX_W-1:0];
                fill_next  = fill_reg + CNT_W'(1);
                state_next = ST_EMIT;
            end
            ST_SHIFT_DN: begin
                mem_we = 1'b1;
                mem_wa = IDX_W'(cnt_reg - CNT_W'(1));
                mem_wd = rd_data_reg;
                if (read_last) begin
                    fill_next  = fill_last;
                    state_next = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    rd_addr  = IDX_W'(cnt_reg + CNT_W'(1));
                end
            end
            ST_READ: begin
                push.valid           = 1'b1;
                push.word.status     = STAT_DONE;
                push.word.out_record = RECORD_W'(rd_data_reg);
                push.word.out_valid  = 1'b1;
                push.word.last       = read_last;
                if (push_ready) begin
                    if (read_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        rd_addr  = IDX_W'(cnt_reg + CNT_W'(1));
                    end
                end
            end
            ST_EMIT: begin
                push.valid = 1'b1;
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        rec_reg    <= rec_next;
        cnt_reg    <= cnt_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        dup_reg    <= dup_next;
        status_reg <= status_next;
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            failed_reg <= 1'b0;
            policy_reg <= '0;
            sorted_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            failed_reg <= failed_next;
            policy_reg <= policy_next;
            sorted_reg <= sorted_next;
        end
    end

    rsmt_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== hdl/rsmt_out_buf.sv =====
// Two-word result queue between the table sequencer and the result channel.
module rsmt_out_buf
    import rsmt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  push_req_t push,
    output logic      push_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    out_word_t   slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign m_valid    = (count_reg != 2'd0);
    assign m_data     = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.word;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== bench/merge_table_checker.sv =====
// Result predictor and comparator for the record set merge table channels.
`timescale 1ns / 1ps

module merge_table_checker
    import rsmt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_word_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_word_t              m_data,
    output int                     fail_count,
    output int                     words_pending,
    output int                     words_checked,
    output logic                   table_failed
);

    localparam logic [RECORD_W-1:0] RECORD_MASK = (DEF_RECORD_BYTES == 8) ? '1 :
        ((64'd1 << (8 * DEF_RECORD_BYTES)) - 64'd1);

    logic [RECORD_W-1:0] held_records [DEF_TABLE_DEPTH];
    int                  held_count;
    logic [POLICY_W-1:0] dup_policy;
    logic                keep_sorted;
    out_word_t           expected_words [$];

    function automatic void push_result(logic [STATUS_W-1:0] status,
                                        logic [RECORD_W-1:0] rec, logic valid, logic last);
        out_word_t w;
        w.status       = status;
        w.out_record   = rec & RECORD_MASK;
        w.out_valid    = valid;
        w.last         = last;
        w.entry_count  = ENTRY_CNT_W'(held_count);
        w.merge_failed = table_failed;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic int find_record(logic [RECORD_W-1:0] rec);
        int i;
        for (i = 0; i < held_count; i++) begin
            if (held_records[i] == rec) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [STATUS_W-1:0] add_record(logic [RECORD_W-1:0] rec);
        int pos;
        int i;
        pos = held_count;
        if (find_record(rec) >= 0) begin
            if (dup_policy == POLICY_SKIP) begin
                return STAT_SKIPPED;
            end
            if (dup_policy == POLICY_REJECT) begin
                table_failed = 1'b1;
                return STAT_DUP_REJ;
            end
        end
        if (held_count >= DEF_TABLE_DEPTH) begin
            table_failed = 1'b1;
            return STAT_FULL;
        end
        if (keep_sorted) begin
            for (i = 0; i < held_count && pos == held_count; i++) begin
                if (held_records[i] >= rec) begin
                    pos = i;
                end
            end
        end
        for (i = held_count; i > pos; i--) begin
            held_records[i] = held_records[i-1];
        end
        held_records[pos] = rec;
        held_count++;
        return STAT_DONE;
    endfunction

    function automatic logic [STATUS_W-1:0] remove_record(logic [RECORD_W-1:0] rec);
        int hit;
        int i;
        hit = find_record(rec);
        if (hit < 0) begin
            return STAT_SKIPPED;
        end
        for (i = hit; i + 1 < held_count; i++) begin
            held_records[i] = held_records[i+1];
        end
        held_count--;
        return STAT_DONE;
    endfunction

    function automatic void apply_operation(in_word_t w);
        logic [RECORD_W-1:0] rec;
        logic [STATUS_W-1:0] status;
        int i;
        rec = w.record & RECORD_MASK;
        status = STAT_DONE;
        if (w.mode == MODE_BEGIN) begin
            held_count = 0;
            table_failed = 1'b0;
            push_result(STAT_DONE, '0, 1'b0, 1'b1);
            return;
        end
        if (table_failed) begin
            push_result(STAT_IGNORED, '0, 1'b0, 1'b1);
            return;
        end
        case (w.mode)
            MODE_LOAD: begin
                if (held_count >= DEF_TABLE_DEPTH) begin
                    table_failed = 1'b1;
                    status = STAT_FULL;
                end else begin
                    held_records[held_count] = rec;
                    held_count++;
                end
            end
            MODE_CLEAR: begin
                held_count = 0;
            end
            MODE_ADD: begin
                status = add_record(rec);
            end
            MODE_REMOVE: begin
                status = remove_record(rec);
            end
            MODE_READ: begin
                if (held_count == 0) begin
                    push_result(STAT_DONE, '0, 1'b0, 1'b1);
                end else begin
                    for (i = 0; i < held_count; i++) begin
                        push_result(STAT_DONE, held_records[i], 1'b1, i + 1 == held_count);
                    end
                end
                return;
            end
            default: begin
                table_failed = 1'b1;
                status = STAT_UNKNOWN;
            end
        endcase
        push_result(status, '0, 1'b0, 1'b1);
    endfunction

    function automatic void compare_field(string name, logic [RECORD_W-1:0] want,
                                          logic [RECORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result(out_word_t got);
        out_word_t want;
        if (expected_words.size() == 0) begin
            $error("result word with nothing expected: 0x%0h", got);
            fail_count++;
            return;
        end
        want = expected_words.pop_front();
        words_checked++;
        compare_field("status", RECORD_W'(want.status), RECORD_W'(got.status));
        compare_field("out_record", want.out_record, got.out_record);
        compare_field("out_valid", RECORD_W'(want.out_valid), RECORD_W'(got.out_valid));
        compare_field("last", RECORD_W'(want.last), RECORD_W'(got.last));
        compare_field("entry_count", RECORD_W'(want.entry_count),
                      RECORD_W'(got.entry_count));
        compare_field("merge_failed", RECORD_W'(want.merge_failed),
                      RECORD_W'(got.merge_failed));
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count = 0;
            table_failed = 1'b0;
            dup_policy = '0;
            keep_sorted = 1'b0;
            expected_words.delete();
            fail_count = 0;
            words_checked = 0;
            words_pending = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_UNIQUE_POLICY) begin
                    dup_policy = cfg_wdata;
                end else begin
                    keep_sorted = cfg_wdata[0];
                end
            end
            if (s_valid && s_ready) begin
                apply_operation(s_data);
            end
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            words_pending = expected_words.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Stimulus, clock, reset and verdict for the record set merge table.
`timescale 1ns / 1ps

module testbench;
    import rsmt_pkg::*;

    localparam logic [MODE_W-1:0]   MODE_UNKNOWN_LO = 3'd6;
    localparam logic [MODE_W-1:0]   MODE_UNKNOWN_HI = 3'd7;
    localparam logic [POLICY_W-1:0] POLICY_KEEP     = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_SPARE    = 2'd3;
    localparam int RANDOM_WORDS   = 200;
    localparam int PHASES         = 7;
    localparam int FILL_PHASES    = 3;
    localparam int CALM_PHASE     = 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;

    localparam logic [POLICY_W-1:0] PHASE_POLICY [PHASES] = '{POLICY_KEEP, POLICY_SKIP,
        POLICY_REJECT, POLICY_SPARE, POLICY_SKIP, POLICY_KEEP, POLICY_REJECT};
    localparam logic PHASE_SORTED [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    in_word_t               s_data;
    logic                   m_valid;
    logic                   m_ready = 1'b1;
    out_word_t              m_data;

    int   fail_count;
    int   words_pending;
    int   words_checked;
    logic table_failed;

    logic                calm;
    int                  ready_hold = 0;
    int                  idle_cycles = 0;
    int                  words_sent = 0;
    int                  counted_words = 0;
    int                  settings_used = 0;
    logic [RECORD_W-1:0] record_pool [8];

    record_set_merge_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    merge_table_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .words_checked (words_checked),
        .table_failed  (table_failed)
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [RECORD_W-1:0] pick_record();
        if ($urandom_range(0, 99) < 65) begin
            return record_pool[$urandom_range(0, 7)];
        end
        return {$urandom, $urandom};
    endfunction

    always @(negedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold--;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
            ready_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [RECORD_W-1:0] rec);
        int gap;
        gap = pick_gap();
        counted_words++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= {mode, rec};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (words_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_registers(input logic [POLICY_W-1:0] policy, input logic sorted);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_UNIQUE_POLICY;
        cfg_wdata <= policy;
        @(negedge aclk);
        cfg_index <= CFG_SORTED_MODE;
        cfg_wdata <= {1'b0, sorted};
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic refresh_pool();
        int k;
        record_pool[0] = '0;
        record_pool[1] = '1;
        record_pool[2] = 64'h8000_0000_0000_0000;
        record_pool[3] = 64'h7FFF_FFFF_FFFF_FFFF;
        for (k = 4; k < 8; k++) begin
            record_pool[k] = {$urandom, $urandom};
        end
    endtask

    task automatic fill_table();
        logic [RECORD_W-1:0] first_rec;
        first_rec = {$urandom, $urandom};
        send_word(MODE_BEGIN, '0);
        send_word(MODE_ADD, first_rec);
        repeat (DEF_TABLE_DEPTH - 1) begin
            send_word(($urandom_range(0, 3) == 0) ? MODE_LOAD : MODE_ADD, {$urandom, $urandom});
        end
        send_word(MODE_READ, '0);
        send_word(MODE_ADD, first_rec);
        send_word(MODE_ADD, {$urandom, $urandom});
        send_word(MODE_LOAD, {$urandom, $urandom});
        send_word(MODE_READ, '0);
    endtask

    task automatic run_sequence();
        int ops;
        int roll;
        logic [MODE_W-1:0] mode;
        send_word(MODE_BEGIN, pick_record());
        repeat ($urandom_range(0, 4)) send_word(MODE_LOAD, pick_record());
        ops = $urandom_range(4, 16);
        repeat (ops) begin
            roll = $urandom_range(0, 99);
            if (table_failed && roll < 60) begin
                mode = MODE_BEGIN;
            end else if (roll < 12) begin
                mode = MODE_LOAD;
            end else if (roll < 15) begin
                mode = MODE_CLEAR;
            end else if (roll < 55) begin
                mode = MODE_ADD;
            end else if (roll < 83) begin
                mode = MODE_REMOVE;
            end else if (roll < 93) begin
                mode = MODE_READ;
            end else if (roll < 95) begin
                mode = MODE_UNKNOWN_LO;
            end else if (roll < 97) begin
                mode = MODE_UNKNOWN_HI;
            end else begin
                mode = MODE_BEGIN;
            end
            send_word(mode, pick_record());
        end
        send_word(MODE_READ, pick_record());
    endtask

    initial begin
        int phase;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        calm = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        send_word(MODE_READ, '0);
        send_word(MODE_REMOVE, '0);
        send_word(MODE_LOAD, '1);
        send_word(MODE_LOAD, '0);
        send_word(MODE_ADD, 64'h8000_0000_0000_0000);
        send_word(MODE_ADD, '0);
        send_word(MODE_REMOVE, '0);
        send_word(MODE_READ, '0);
        send_word(MODE_CLEAR, '1);
        send_word(MODE_UNKNOWN_LO, '0);
        send_word(MODE_ADD, 64'h0000_0000_0000_1234);
        send_word(MODE_READ, '0);
        send_word(MODE_BEGIN, '1);
        send_word(MODE_UNKNOWN_HI, '1);
        send_word(MODE_BEGIN, '0);
        write_registers(POLICY_REJECT, 1'b1);
        send_word(MODE_ADD, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(MODE_ADD, 64'h8000_0000_0000_0000);
        send_word(MODE_ADD, 64'h0000_0000_0000_0001);
        send_word(MODE_ADD, 64'h0100_0000_0000_0000);
        send_word(MODE_READ, '0);
        send_word(MODE_ADD, 64'h8000_0000_0000_0000);
        send_word(MODE_LOAD, '0);
        send_word(MODE_BEGIN, '0);
        write_registers(POLICY_SKIP, 1'b0);
        send_word(MODE_ADD, 64'hFF00_0000_0000_00FF);
        send_word(MODE_ADD, 64'hFF00_0000_0000_00FF);
        send_word(MODE_READ, '0);

        counted_words = 0;
        for (phase = 0; phase < PHASES; phase++) begin
            write_registers(PHASE_POLICY[phase], PHASE_SORTED[phase]);
            calm = (phase == CALM_PHASE);
            refresh_pool();
            if (phase < FILL_PHASES) begin
                fill_table();
            end
            do begin
                run_sequence();
            end while (counted_words < RANDOM_WORDS * (phase + 1) / PHASES);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d operation words and checked %0d result words under %0d settings.",
                 words_sent, words_checked, settings_used);
        $display("Covered all policies, append and sorted insert, full table and recovery.");
        if (fail_count == 0 && words_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
